/* rtl/contact_ising_site_update_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the contact Ising site update unit
// Shorthand for clocked checks that use the enclosing clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef CONTACT_ISING_SITE_UPDATE_UNIT_MACROS_SVH
`define CONTACT_ISING_SITE_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication.
`define CISU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cisu check failed");

// Next-cycle implication.
`define CISU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cisu check failed");

`endif

/* rtl/cisu_pkg.sv */
// ---------------------------------------------------------------------------
// cisu_pkg
// Shared constants, codes, offset tables and control structs.
// ---------------------------------------------------------------------------
package cisu_pkg;

    localparam int SIDE       = 256;
    localparam int COORD_W    = $clog2(SIDE);
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int MAX_RADIUS = 3;
    localparam int NB_MAX     = 2 * MAX_RADIUS * (MAX_RADIUS + 1);
    localparam int NB_IDX_W   = $clog2(NB_MAX);
    localparam int NB_CNT_W   = $clog2(NB_MAX + 1);
    localparam int OFS_W      = $clog2(MAX_RADIUS + 1) + 1;
    localparam int SUM_W      = $clog2(NB_MAX + 1) + 1;
    localparam int CNT_W      = 17;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    typedef logic [1:0] site_t;
    localparam site_t SITE_EMPTY = 2'd0;
    localparam site_t SITE_UP    = 2'd1;
    localparam site_t SITE_DOWN  = 2'd2;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_INIT   = 1'b1;

    localparam logic [1:0] PICK_LEFT  = 2'd0;
    localparam logic [1:0] PICK_DOWN  = 2'd1;
    localparam logic [1:0] PICK_UP    = 2'd2;
    localparam logic [1:0] PICK_RIGHT = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_BIRTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEATH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_J      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_B      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BETA   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd5;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] EXP_C1    = 16'd45426;
    localparam logic [13:0] EXP_C2    = 14'd15743;
    localparam logic [11:0] EXP_C3    = 12'd3085;

    typedef struct packed {
        logic [16:0]        birth;
        logic [16:0]        death;
        logic signed [15:0] coupling_j;
        logic signed [15:0] field_b;
        logic [21:0]        beta;
        logic [1:0]         radius;
    } cfg_t;

    typedef struct packed {
        logic in_ready;
        logic rd_focal;
        logic cap_before;
        logic rd_nbr;
        logic set_nbr;
        logic set_die;
        logic set_flip;
        logic sum_start;
        logic sum_issue;
        logic mul_j;
        logic mul_de;
        logic mul_lo;
        logic mul_hi;
        logic mul_x;
        logic mul_z;
        logic poly_u;
        logic poly_w;
        logic poly_h;
        logic poly_p;
        logic clr_write;
        logic init_write;
        logic wr_site;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic is_init;
        logic before_empty;
        logic death_hit;
        logic birth_hit;
        logic sum_last;
        logic de_neg;
        logic flip_ok;
        logic clr_last;
        logic out_free;
    } ctl_stat_t;

    typedef logic signed [OFS_W-1:0] ofs_arr_t [NB_MAX];

    // Diamond offsets ordered ring by ring, so the first 2r(r+1) entries
    // cover radius r.
    function automatic ofs_arr_t build_ofs(input bit want_y);
        ofs_arr_t a;
        int n;
        a = '{default: '0};
        n = 0;
        for (int d = 1; d <= MAX_RADIUS; d++) begin
            for (int i = -d; i <= d; i++) begin
                for (int j = -d; j <= d; j++) begin
                    if (((i < 0) ? -i : i) + ((j < 0) ? -j : j) == d) begin
                        a[n] = want_y ? OFS_W'(j) : OFS_W'(i);
                        n++;
                    end
                end
            end
        end
        return a;
    endfunction

    localparam ofs_arr_t NB_DX = build_ofs(1'b0);
    localparam ofs_arr_t NB_DY = build_ofs(1'b1);

    function automatic logic [NB_CNT_W-1:0] nb_count(input logic [1:0] radius);
        int r;
        r = int'(radius);
        if (r < 1) r = 1;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        return NB_CNT_W'(2 * r * (r + 1));
    endfunction

endpackage

/* rtl/cisu_if.sv */
// ---------------------------------------------------------------------------
// cisu request and result channels
// Valid/ready channels carrying one request item or one result item.
// ---------------------------------------------------------------------------
interface cisu_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  site_x;
    logic [7:0]  site_y;
    logic [1:0]  neighbor_pick;
    logic [15:0] uniform_event;
    logic [15:0] uniform_accept;
    logic        seed_spin;

    modport source (
        output valid, opcode, site_x, site_y, neighbor_pick,
               uniform_event, uniform_accept, seed_spin,
        input  ready
    );
    modport sink (
        input  valid, opcode, site_x, site_y, neighbor_pick,
               uniform_event, uniform_accept, seed_spin,
        output ready
    );
endinterface

interface cisu_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  site_state;
    logic        site_changed;
    logic [16:0] occupied_count;
    logic [16:0] up_count;
    logic [16:0] down_count;
    logic        extinct;

    modport source (
        output valid, site_state, site_changed, occupied_count, up_count,
               down_count, extinct,
        input  ready
    );
    modport sink (
        input  valid, site_state, site_changed, occupied_count, up_count,
               down_count, extinct,
        output ready
    );
endinterface

/* rtl/contact_ising_site_update_unit.sv */
// ---------------------------------------------------------------------------
// contact_ising_site_update_unit
// Contact-process / Ising Metropolis update engine on a 256 x 256 torus.
// ---------------------------------------------------------------------------
// The unit keeps a 256 x 256 wrapped lattice of empty/up/down sites in one
// single-port-read memory plus running occupied, up and down totals. After
// reset it sweeps the lattice to empty and takes no request until that is
// done (register writes are taken throughout). One request is worked at a
// time; a finished result sits in an output register so the next request
// can be taken while it waits. An empty site reads one neighbor, a dying
// site is written without further reads, and a spin test reads 4, 12 or 24
// neighbors for radius 1, 2 or 3 through the one memory read port; when the
// energy does not fall it also runs the chain of registered multiplies in
// the exponential. An init request clears the whole lattice again.
// ---------------------------------------------------------------------------
module contact_ising_site_update_unit import cisu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    cisu_req_if.sink           req,
    cisu_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Register file
    cfg_t                  cfg_reg;
    ctl_cmd_t              cmd;
    ctl_stat_t             st;
    logic                  wr_req;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_req  = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // Write a register on the access cycle of an APB write; drop writes
    // to unmapped addresses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.birth      <= 17'd65536;
            cfg_reg.death      <= 17'd0;
            cfg_reg.coupling_j <= -16'sd16384;
            cfg_reg.field_b    <= 16'sd0;
            cfg_reg.beta       <= 22'd4096000;
            cfg_reg.radius     <= 2'd1;
        end
        else if (wr_req)
        begin
            case (reg_idx)
                REG_BIRTH:  cfg_reg.birth      <= pwdata[16:0];
                REG_DEATH:  cfg_reg.death      <= pwdata[16:0];
                REG_J:      cfg_reg.coupling_j <= pwdata[15:0];
                REG_B:      cfg_reg.field_b    <= pwdata[15:0];
                REG_BETA:   cfg_reg.beta       <= pwdata[21:0];
                REG_RADIUS: cfg_reg.radius     <= pwdata[1:0];
                default:    cfg_reg.radius     <= cfg_reg.radius;
            endcase
        end
    end

    // Read back the raw register bits, zero-extended.
    always_comb
    begin
        case (reg_idx)
            REG_BIRTH:  prdata = 32'(cfg_reg.birth);
            REG_DEATH:  prdata = 32'(cfg_reg.death);
            REG_J:      prdata = 32'(unsigned'(cfg_reg.coupling_j));
            REG_B:      prdata = 32'(unsigned'(cfg_reg.field_b));
            REG_BETA:   prdata = 32'(cfg_reg.beta);
            REG_RADIUS: prdata = 32'(cfg_reg.radius);
            default:    prdata = 32'd0;
        endcase
    end

    // Sequencer: walks each request through read, decide, evaluate, write.
    cisu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Lattice memory, arithmetic and the result register.
    cisu_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cmd   (cmd),
        .st    (st),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* rtl/cisu_datapath.sv */
// ---------------------------------------------------------------------------
// cisu_datapath
// Lattice memory, counters, energy and acceptance arithmetic, result register.
// ---------------------------------------------------------------------------
module cisu_datapath import cisu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  ctl_cmd_t   cmd,
    output ctl_stat_t  st,
    cisu_req_if.sink   req,
    cisu_rsp_if.source rsp
);

    localparam int JS_W  = 16 + SUM_W;
    localparam int DF_W  = JS_W + 1;
    localparam int DE_W  = DF_W + 1;
    localparam int MAG_W = DE_W - 1;
    localparam int BL_W  = 11;
    localparam int BH_W  = 22 - BL_W;
    localparam int PL_W  = MAG_W + BL_W;
    localparam int PH_W  = MAG_W + BH_W;
    localparam int X_W   = MAG_W + 22;
    localparam int T_W   = X_W - 10;

    site_t lattice [2**ADDR_W];

    logic               op_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [1:0]         pick_reg;
    logic [15:0]        ev_reg, acc_reg;
    logic               seed_reg;
    site_t              rd_data_reg, before_reg, after_reg;
    logic [NB_IDX_W-1:0] idx_reg;
    logic               pend_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [JS_W-1:0]  jsum_reg;
    logic signed [DE_W-1:0]  de_reg;
    logic [PL_W-1:0]    plo_reg;
    logic [PH_W-1:0]    phi_reg;
    logic [20:0]        t_reg;
    logic               sat_reg;
    logic [15:0]        f_reg;
    logic [4:0]         k_reg;
    logic               zero_reg;
    logic [11:0]        u_reg;
    logic [13:0]        w_reg;
    logic [15:0]        h_reg;
    logic [16:0]        p_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0]   occ_reg, up_reg, down_reg;
    logic               out_valid_reg;
    site_t              out_state_reg;
    logic               out_changed_reg;
    logic [CNT_W-1:0]   out_occ_reg, out_up_reg, out_down_reg;
    logic               out_extinct_reg;

    logic               fire;
    logic [ADDR_W-1:0]  focal_addr, nbr_addr, dia_addr, rd_addr, wr_addr;
    logic [COORD_W-1:0] nx, ny;
    logic               rd_en, wr_en;
    site_t              wr_data, flip_state;
    logic signed [DF_W-1:0] diff;
    logic signed [DE_W-1:0] dbl;
    logic [X_W-1:0]     x_sum;
    logic [T_W-1:0]     t_full;
    logic [37:0]        z_prod;
    logic [21:0]        z_val;
    logic [13:0]        v_val;
    logic [15:0]        q_val;
    logic [16:0]        m_val;
    logic [NB_CNT_W-1:0] nb_n;

    assign fire      = req.valid & cmd.in_ready;
    assign req.ready = cmd.in_ready;

    // Request capture; init always targets the centre site.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            op_reg   <= req.opcode;
            x_reg    <= (req.opcode == OP_INIT) ? COORD_W'(SIDE / 2) : COORD_W'(req.site_x);
            y_reg    <= (req.opcode == OP_INIT) ? COORD_W'(SIDE / 2) : COORD_W'(req.site_y);
            pick_reg <= req.neighbor_pick;
            ev_reg   <= req.uniform_event;
            acc_reg  <= req.uniform_accept;
            seed_reg <= req.seed_spin;
        end
    end

    // Address generation
    always_comb
    begin
        nx = x_reg;
        ny = y_reg;
        case (pick_reg)
            PICK_LEFT:  nx = x_reg - 1'b1;
            PICK_DOWN:  ny = y_reg - 1'b1;
            PICK_UP:    ny = y_reg + 1'b1;
            PICK_RIGHT: nx = x_reg + 1'b1;
            default:    nx = x_reg;
        endcase
    end

    assign focal_addr = {y_reg, x_reg};
    assign nbr_addr   = {ny, nx};
    assign dia_addr   = {y_reg + COORD_W'(NB_DY[idx_reg]), x_reg + COORD_W'(NB_DX[idx_reg])};
    assign rd_en      = cmd.rd_focal | cmd.rd_nbr | cmd.sum_issue;
    assign rd_addr    = cmd.rd_focal ? focal_addr : (cmd.rd_nbr ? nbr_addr : dia_addr);

    assign wr_en   = cmd.clr_write | cmd.init_write | cmd.wr_site;
    assign wr_addr = cmd.clr_write ? clr_cnt_reg : focal_addr;
    assign wr_data = cmd.clr_write ? SITE_EMPTY :
                     (cmd.init_write ? (seed_reg ? SITE_UP : SITE_DOWN) : after_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lattice[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= lattice[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Site state decision; a death is decided in the same cycle the focal
    // state is captured.
    assign flip_state = (before_reg == SITE_UP) ? SITE_DOWN : SITE_UP;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_before)
        begin
            before_reg <= rd_data_reg;
            after_reg  <= cmd.set_die ? SITE_EMPTY : rd_data_reg;
        end
        else if (cmd.set_nbr)
        begin
            after_reg <= rd_data_reg;
        end
        else if (cmd.set_flip)
        begin
            after_reg <= flip_state;
        end
        else if (cmd.init_write)
        begin
            after_reg <= seed_reg ? SITE_UP : SITE_DOWN;
        end
    end

    // Diamond spin sum, one read issued per cycle, accumulated in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.sum_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_start)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (cmd.sum_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (pend_reg)
            begin
                case (rd_data_reg)
                    SITE_UP:   sum_reg <= sum_reg + SUM_W'(1);
                    SITE_DOWN: sum_reg <= sum_reg - SUM_W'(1);
                    default:   sum_reg <= sum_reg;
                endcase
            end
        end
    end

    // Energy and acceptance probability
    assign diff   = DF_W'(jsum_reg) - DF_W'(cfg.field_b);
    assign dbl    = DE_W'(diff) <<< 1;
    assign x_sum  = X_W'(plo_reg) + (X_W'(phi_reg) << BL_W);
    assign t_full = x_sum[X_W-1:10];
    assign z_prod = 38'(t_reg) * 38'(LOG2E_Q16);
    assign z_val  = z_prod[37:16];
    assign v_val  = EXP_C2 - 14'(u_reg);
    assign q_val  = EXP_C1 - 16'(w_reg);
    assign m_val  = 17'h10000 - 17'(h_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_j)
        begin
            jsum_reg <= JS_W'(cfg.coupling_j) * JS_W'(sum_reg);
        end
        if (cmd.mul_de)
        begin
            de_reg <= (before_reg == SITE_UP) ? -dbl : dbl;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= PL_W'(de_reg[MAG_W-1:0]) * PL_W'(cfg.beta[BL_W-1:0]);
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= PH_W'(de_reg[MAG_W-1:0]) * PH_W'(cfg.beta[21:BL_W]);
        end
        if (cmd.mul_x)
        begin
            t_reg   <= t_full[20:0];
            sat_reg <= |t_full[T_W-1:21];
        end
        if (cmd.mul_z)
        begin
            f_reg    <= z_val[15:0];
            k_reg    <= z_val[20:16];
            zero_reg <= sat_reg | (z_val[21:16] >= 6'd17);
        end
        if (cmd.poly_u)
        begin
            u_reg <= 12'((28'(f_reg) * 28'(EXP_C3)) >> 16);
        end
        if (cmd.poly_w)
        begin
            w_reg <= 14'((30'(f_reg) * 30'(v_val)) >> 16);
        end
        if (cmd.poly_h)
        begin
            h_reg <= 16'((32'(f_reg) * 32'(q_val)) >> 16);
        end
        if (cmd.poly_p)
        begin
            p_reg <= zero_reg ? 17'd0 : (m_val >> k_reg);
        end
    end

    // Site totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            up_reg   <= '0;
            down_reg <= '0;
        end
        else if (cmd.init_write)
        begin
            occ_reg  <= CNT_W'(1);
            up_reg   <= CNT_W'(seed_reg);
            down_reg <= CNT_W'(!seed_reg);
        end
        else if (cmd.wr_site)
        begin
            occ_reg  <= occ_reg + CNT_W'(after_reg != SITE_EMPTY)
                                - CNT_W'(before_reg != SITE_EMPTY);
            up_reg   <= up_reg + CNT_W'(after_reg == SITE_UP)
                               - CNT_W'(before_reg == SITE_UP);
            down_reg <= down_reg + CNT_W'(after_reg == SITE_DOWN)
                                 - CNT_W'(before_reg == SITE_DOWN);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_state_reg   <= after_reg;
            out_changed_reg <= (after_reg != before_reg);
            out_occ_reg     <= occ_reg;
            out_up_reg      <= up_reg;
            out_down_reg    <= down_reg;
            out_extinct_reg <= (occ_reg == '0);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.site_state     = out_state_reg;
    assign rsp.site_changed   = out_changed_reg;
    assign rsp.occupied_count = out_occ_reg;
    assign rsp.up_count       = out_up_reg;
    assign rsp.down_count     = out_down_reg;
    assign rsp.extinct        = out_extinct_reg;

    // Status
    assign nb_n            = nb_count(cfg.radius);
    assign st.req_valid    = req.valid;
    assign st.is_init      = (op_reg == OP_INIT);
    assign st.before_empty = (rd_data_reg == SITE_EMPTY);
    assign st.death_hit    = ({1'b0, ev_reg} < cfg.death);
    assign st.birth_hit    = ({1'b0, ev_reg} < cfg.birth)
                             && (rd_data_reg == SITE_UP || rd_data_reg == SITE_DOWN);
    assign st.sum_last     = (idx_reg == NB_IDX_W'(nb_n - 1'b1));
    assign st.de_neg       = de_reg[DE_W-1];
    assign st.flip_ok      = ({1'b0, acc_reg} < p_reg);
    assign st.clr_last     = &clr_cnt_reg;
    assign st.out_free     = !out_valid_reg || rsp.ready;

endmodule

/* rtl/cisu_ctrl.sv */
// ---------------------------------------------------------------------------
// cisu_ctrl
// Sequencer for clearing, site update, energy evaluation and result hand-off.
// ---------------------------------------------------------------------------
`include "contact_ising_site_update_unit_macros.svh"

module cisu_ctrl import cisu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_stat_t st,
    output ctl_cmd_t  cmd
);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_FOC  = 5'd2;
    localparam logic [4:0] S_FOCW = 5'd3;
    localparam logic [4:0] S_NBR  = 5'd4;
    localparam logic [4:0] S_NBRW = 5'd5;
    localparam logic [4:0] S_SUM  = 5'd6;
    localparam logic [4:0] S_SUMW = 5'd7;
    localparam logic [4:0] S_MJ   = 5'd8;
    localparam logic [4:0] S_MDE  = 5'd9;
    localparam logic [4:0] S_DEC  = 5'd10;
    localparam logic [4:0] S_MLO  = 5'd11;
    localparam logic [4:0] S_MHI  = 5'd12;
    localparam logic [4:0] S_XS   = 5'd13;
    localparam logic [4:0] S_ZM   = 5'd14;
    localparam logic [4:0] S_PU   = 5'd15;
    localparam logic [4:0] S_PW   = 5'd16;
    localparam logic [4:0] S_PH   = 5'd17;
    localparam logic [4:0] S_PP   = 5'd18;
    localparam logic [4:0] S_ACC  = 5'd19;
    localparam logic [4:0] S_WR   = 5'd20;
    localparam logic [4:0] S_INIT = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    logic [4:0] state_reg, state_next;
    logic       init_mode_reg, init_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_mode_reg <= init_mode_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        init_mode_next = init_mode_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (st.clr_last)
                begin
                    state_next     = init_mode_reg ? S_INIT : S_IDLE;
                    init_mode_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.req_valid)
                begin
                    state_next = S_FOC;
                end
            end
            S_FOC:
            begin
                cmd.rd_focal = 1'b1;
                state_next   = S_FOCW;
            end
            S_FOCW:
            begin
                cmd.cap_before = 1'b1;
                if (st.is_init)
                begin
                    init_mode_next = 1'b1;
                    state_next     = S_CLR;
                end
                else if (st.before_empty)
                begin
                    state_next = S_NBR;
                end
                else if (st.death_hit)
                begin
                    cmd.set_die = 1'b1;
                    state_next  = S_WR;
                end
                else
                begin
                    cmd.sum_start = 1'b1;
                    state_next    = S_SUM;
                end
            end
            S_NBR:
            begin
                cmd.rd_nbr = 1'b1;
                state_next = S_NBRW;
            end
            S_NBRW:
            begin
                cmd.set_nbr = st.birth_hit;
                state_next  = S_WR;
            end
            S_SUM:
            begin
                cmd.sum_issue = 1'b1;
                if (st.sum_last)
                begin
                    state_next = S_SUMW;
                end
            end
            S_SUMW: state_next = S_MJ;
            S_MJ:
            begin
                cmd.mul_j  = 1'b1;
                state_next = S_MDE;
            end
            S_MDE:
            begin
                cmd.mul_de = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (st.de_neg)
                begin
                    cmd.set_flip = 1'b1;
                    state_next   = S_WR;
                end
                else
                begin
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_XS;
            end
            S_XS:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_ZM;
            end
            S_ZM:
            begin
                cmd.mul_z  = 1'b1;
                state_next = S_PU;
            end
            S_PU:
            begin
                cmd.poly_u = 1'b1;
                state_next = S_PW;
            end
            S_PW:
            begin
                cmd.poly_w = 1'b1;
                state_next = S_PH;
            end
            S_PH:
            begin
                cmd.poly_h = 1'b1;
                state_next = S_PP;
            end
            S_PP:
            begin
                cmd.poly_p = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.set_flip = st.flip_ok;
                state_next   = S_WR;
            end
            S_WR:
            begin
                cmd.wr_site = 1'b1;
                state_next  = S_OUT;
            end
            S_INIT:
            begin
                cmd.init_write = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `CISU_ASSERT_NEXT(a_write_then_out, state_reg == S_WR || state_reg == S_INIT, state_reg == S_OUT)
    `CISU_ASSERT_NEXT(a_neg_de_flips, state_reg == S_DEC && st.de_neg, state_reg == S_WR)
    `CISU_ASSERT_NEXT(a_out_to_idle, state_reg == S_OUT && st.out_free, state_reg == S_IDLE)
    `CISU_ASSERT_SAME(a_clear_no_take, state_reg == S_CLR, !cmd.in_ready)

endmodule
